// ===== rtl/hps_pkg.sv =====
// ----------------------------------------------------------------------------
// hps_pkg: shared types and constants of the point distance heapsort
// Sizes of the point store, the layout of a stored entry, the sequencer
// states and the control word of the squaring unit.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_W    = 16;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = ADDR_W + 1;
  localparam int KEY_W      = 2 * COORD_W;

  // one store entry: squared distance next to the point it belongs to
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic    mul_en;
    acc_op_t acc_op;
  } key_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_SUM,
    ST_WR,
    ST_SORT,
    ST_NODE,
    ST_CUR,
    ST_LEFT,
    ST_RIGHT,
    ST_CMP,
    ST_DONE,
    ST_X0,
    ST_XE,
    ST_XW,
    ST_ERD,
    ST_ELD,
    ST_EOUT
  } state_t;

endpackage

// ===== rtl/hps_ram.sv =====
// ----------------------------------------------------------------------------
// hps_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hps_key_unit.sv =====
// ----------------------------------------------------------------------------
// hps_key_unit: shared squaring multiplier with accumulator
// Squares the magnitude of one coordinate per cycle while mul_en is set and sums the squares.
// ----------------------------------------------------------------------------
module hps_key_unit import hps_pkg::*; (
  input  logic               clk,
  input  key_ctl_t           ctl,
  input  logic [COORD_W-1:0] operand,
  output logic [KEY_W-1:0]   key
);

  logic [COORD_W-1:0] mag;
  logic [KEY_W-1:0]   prod;

  // magnitude of a two's complement value; the most negative code maps to 2^(W-1)
  assign mag = operand[COORD_W-1] ? (~operand + 1'b1) : operand;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod <= KEY_W'(mag) * KEY_W'(mag);
    end
    case (ctl.acc_op)
      ACC_LOAD: key <= prod;
      ACC_ADD:  key <= key + prod;
      default:  key <= key;
    endcase
  end

endmodule

// ===== rtl/heapsort_points_by_distance.sv =====
// ----------------------------------------------------------------------------
// heapsort_points_by_distance: sort 2D points by squared distance
// Collects points, heapsorts them by x*x+y*y and emits them in order.
// ----------------------------------------------------------------------------
// Points arrive one item at a time as signed Q8.8 x and y; the item marked
// is_last closes the set. Up to MAX_POINTS points are kept; any further point
// (the last one too) is dropped and overflow is raised on every result of that
// set. Each point is loaded in the steps accept, square x, square y, sum and
// store, in turn on the single shared squaring multiplier. After the last item the
// block runs an in-place binary heapsort over the point store: the heap is built
// from the last parent down to the root, then the root is moved to the end and
// the old last leaf is sifted down from the root. Every sift level, build pass
// and extract pass is bound by the one read port of the store.
// Results then leave one at a time, ascending by distance; the next result is
// read from the store only after out_ready has taken the one before. Equal
// distances leave in the order a swap-based heapsort gives.
// in_ready drops after each stored item while it loads (a dropped item is
// taken at once), and stays low from the last item until the final result
// has been taken. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module heapsort_points_by_distance import hps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] x_coord,
  input  logic [COORD_W-1:0] y_coord,
  input  logic               is_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] sorted_x,
  output logic [COORD_W-1:0] sorted_y,
  output logic               last_out,
  output logic               overflow
);

  state_t state, state_next;

  // control state
  logic [CNT_W-1:0]  count;     // points held in this set
  logic              dropped;   // a point of this set was lost
  logic              extract;   // heap phase: 0 build, 1 extract

  // datapath registers
  logic [COORD_W-1:0] px, py;
  logic               plast;
  logic [CNT_W-1:0]   hsz;      // current heap size
  logic [ADDR_W-1:0]  b;        // build: parent being sifted
  logic [ADDR_W-1:0]  i;        // sift: hole position
  logic [ADDR_W-1:0]  k;        // emit index
  entry_t             cur;      // entry being sifted down
  entry_t             left;     // left child of the hole
  entry_t             root;     // root held during the extract swap
  logic               sel_l;    // left child beat the sifted entry

  // RAM ports
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  entry_t            wdata, rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  // shared units
  key_ctl_t           kctl;
  logic [COORD_W-1:0] kop;
  logic [KEY_W-1:0]   key;
  logic [KEY_W-1:0]   cmp_a, cmp_b;
  logic               lt;

  logic [IDX_W-1:0] l_idx, r_idx;
  logic             l_ok, r_ok;

  assign rdata = entry_t'(rdata_raw);

  hps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (ENTRY_W'(wdata)),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  hps_key_unit u_key (
    .clk     (clk),
    .ctl     (kctl),
    .operand (kop),
    .key     (key)
  );

  // children of the hole and whether they lie inside the heap
  assign l_idx = {i, 1'b1};
  assign r_idx = l_idx + 1'b1;
  assign l_ok  = l_idx < IDX_W'(hsz);
  assign r_ok  = r_idx < IDX_W'(hsz);

  // one comparator serves both child tests
  assign lt = cmp_a < cmp_b;

  always_comb begin
    cmp_a = cur.key;
    cmp_b = rdata.key;
    if (state == ST_CMP && sel_l) begin
      cmp_a = left.key;
    end
  end

  // Next state and control outputs
  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = i;
    wdata      = cur;
    raddr      = i;
    kctl       = '{mul_en: 1'b0, acc_op: ACC_HOLD};
    kop        = px;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < CNT_W'(MAX_POINTS)) begin
            state_next = ST_SQX;
          end else if (is_last) begin
            state_next = ST_SORT;
          end
        end
      end
      ST_SQX: begin
        kctl       = '{mul_en: 1'b1, acc_op: ACC_HOLD};
        state_next = ST_SQY;
      end
      ST_SQY: begin
        kop        = py;
        kctl       = '{mul_en: 1'b1, acc_op: ACC_LOAD};
        state_next = ST_SUM;
      end
      ST_SUM: begin
        kctl       = '{mul_en: 1'b0, acc_op: ACC_ADD};
        state_next = ST_WR;
      end
      ST_WR: begin
        we         = 1'b1;
        waddr      = count[ADDR_W-1:0];
        wdata      = '{key: key, x: px, y: py};
        state_next = plast ? ST_SORT : ST_IDLE;
      end
      ST_SORT: begin
        state_next = (count < CNT_W'(2)) ? ST_ERD : ST_NODE;
      end
      ST_NODE: begin
        raddr      = b;
        state_next = ST_CUR;
      end
      ST_CUR: begin
        state_next = ST_LEFT;
      end
      ST_LEFT: begin
        if (l_ok) begin
          raddr      = l_idx[ADDR_W-1:0];
          state_next = ST_RIGHT;
        end else begin
          we         = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_RIGHT: begin
        if (r_ok) begin
          raddr      = r_idx[ADDR_W-1:0];
          state_next = ST_CMP;
        end else if (lt) begin
          we         = 1'b1;
          wdata      = rdata;
          state_next = ST_LEFT;
        end else begin
          we         = 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_CMP: begin
        we = 1'b1;
        if (lt) begin
          wdata      = rdata;
          state_next = ST_LEFT;
        end else if (sel_l) begin
          wdata      = left;
          state_next = ST_LEFT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!extract) begin
          state_next = (b == '0) ? ST_X0 : ST_NODE;
        end else begin
          state_next = (hsz > CNT_W'(1)) ? ST_X0 : ST_ERD;
        end
      end
      ST_X0: begin
        raddr      = '0;
        state_next = ST_XE;
      end
      ST_XE: begin
        raddr      = ADDR_W'(hsz - 1'b1);
        state_next = ST_XW;
      end
      ST_XW: begin
        we         = 1'b1;
        waddr      = ADDR_W'(hsz - 1'b1);
        wdata      = root;
        state_next = ST_LEFT;
      end
      ST_ERD: begin
        raddr      = k;
        state_next = ST_ELD;
      end
      ST_ELD: begin
        state_next = ST_EOUT;
      end
      ST_EOUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = last_out ? ST_IDLE : ST_ERD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Set bookkeeping: point count, the dropped-point flag and the heap phase flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
      extract <= 1'b0;
    end else begin
      if (state == ST_IDLE && in_valid && count >= CNT_W'(MAX_POINTS)) begin
        dropped <= 1'b1;
      end
      if (state == ST_WR) begin
        count <= count + 1'b1;
      end
      if (state == ST_SORT) begin
        extract <= 1'b0;
      end
      if (state == ST_X0) begin
        extract <= 1'b1;
      end
      // clear the set once its final result is taken
      if (state == ST_EOUT && out_ready && last_out) begin
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        px    <= x_coord;
        py    <= y_coord;
        plast <= is_last;
      end
      ST_SORT: begin
        hsz <= count;
        b   <= ADDR_W'((count >> 1) - 1'b1);
        k   <= '0;
      end
      ST_NODE: begin
        i <= b;
      end
      ST_CUR: begin
        cur <= rdata;
      end
      ST_RIGHT: begin
        left  <= rdata;
        sel_l <= lt;
        if (!r_ok && lt) begin
          i <= l_idx[ADDR_W-1:0];
        end
      end
      ST_CMP: begin
        if (lt) begin
          i <= r_idx[ADDR_W-1:0];
        end else if (sel_l) begin
          i <= l_idx[ADDR_W-1:0];
        end
      end
      ST_DONE: begin
        if (!extract && b != '0) begin
          b <= b - 1'b1;
        end
        k <= '0;
      end
      ST_XE: begin
        root <= rdata;
      end
      ST_XW: begin
        // the old last leaf fills the hole left at the root
        cur <= rdata;
        hsz <= hsz - 1'b1;
        i   <= '0;
      end
      ST_ELD: begin
        sorted_x <= rdata.x;
        sorted_y <= rdata.y;
        last_out <= (CNT_W'(k) == count - 1'b1);
        overflow <= dropped;
      end
      ST_EOUT: begin
        if (out_ready) begin
          k <= k + 1'b1;
        end
      end
      default: begin
        px <= px;
      end
    endcase
  end

  // Assertions
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count beyond store capacity");

  a_store_write_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> (count < CNT_W'(MAX_POINTS)))
    else $error("store write with the store full");

  a_hole_in_heap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LEFT) |-> (IDX_W'(i) < IDX_W'(hsz)))
    else $error("sift hole outside the heap");

  a_no_input_while_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result is pending");

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_out) |=> (count == '0 && !dropped))
    else $error("set not cleared after its final result");

endmodule
